/* rtl/core/r2k_pkg.sv */
// ============================================================================
// Romaji to kana package
// Shared types and the romaji key table. Table lookups are written as
// functions over upper-case folded ASCII.
// ============================================================================
`default_nettype none

package r2k_pkg;

   // Depth of the lookahead window; equals the longest romaji key.
   localparam int unsigned MaxKeyLen = 4;

   // Input item: one UTF-16 code unit and the end-of-string flag.
   typedef struct packed {
      logic [15:0] char_code;
      logic        last_char;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [15:0] out_code;
      logic        from_table;
      logic        run_last;
      logic        string_end;
   } rsp_type;

   // Queued unit: original code, folded ASCII (zero if not ASCII) and flag.
   typedef struct packed {
      logic [15:0] code;
      logic [7:0]  fold;
      logic        last;
   } unit_type;

   // One table hit: up to two kana units, second is zero when unused.
   typedef struct packed {
      logic        hit;
      logic [15:0] first;
      logic [15:0] second;
   } kana_type;

   // Result of a greedy lookup over the whole window.
   typedef struct packed {
      logic        hit;
      logic [2:0]  len;
      logic [15:0] first;
      logic [15:0] second;
   } match_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SECOND
   } state_type;

   // Hiragana codes used in several keys.
   localparam logic [15:0] KanaSmallYa = 16'h3083;
   localparam logic [15:0] KanaSmallYu = 16'h3085;
   localparam logic [15:0] KanaSmallYo = 16'h3087;
   localparam logic [15:0] KanaSmallTsu = 16'h3063;

   // Fold a UTF-16 unit to an upper-case ASCII byte; non-ASCII gives zero.
   function automatic logic [7:0] fold_unit(input logic [15:0] u);
      logic [7:0] b;
      b = u[7:0];
      if (u[15:7] != 9'd0) begin
         fold_unit = 8'h00;
      end else if (b >= 8'h61 && b <= 8'h7A) begin
         fold_unit = b - 8'h20;
      end else begin
         fold_unit = b;
      end
   endfunction

   function automatic kana_type kana(input logic [15:0] f, input logic [15:0] s);
      kana_type k;
      k.hit    = 1'b1;
      k.first  = f;
      k.second = s;
      kana = k;
   endfunction

   // Three-letter keys.
   function automatic kana_type key3(input logic [23:0] t);
      kana_type k;
      k = '0;
      case (t)
         "XYA": k = kana(16'h3083, 16'h0000);
         "XYU": k = kana(16'h3085, 16'h0000);
         "XYO": k = kana(16'h3087, 16'h0000);
         "SHI": k = kana(16'h3057, 16'h0000);
         "CHI": k = kana(16'h3061, 16'h0000);
         "TSU": k = kana(16'h3064, 16'h0000);
         "KYA": k = kana(16'h304D, KanaSmallYa);
         "KYU": k = kana(16'h304D, KanaSmallYu);
         "KYO": k = kana(16'h304D, KanaSmallYo);
         "GYA": k = kana(16'h304E, KanaSmallYa);
         "GYU": k = kana(16'h304E, KanaSmallYu);
         "GYO": k = kana(16'h304E, KanaSmallYo);
         "SHA": k = kana(16'h3057, KanaSmallYa);
         "SHU": k = kana(16'h3057, KanaSmallYu);
         "SHO": k = kana(16'h3057, KanaSmallYo);
         "ZYA": k = kana(16'h3058, KanaSmallYa);
         "ZYU": k = kana(16'h3058, KanaSmallYu);
         "ZYO": k = kana(16'h3058, KanaSmallYo);
         "CHA": k = kana(16'h3061, KanaSmallYa);
         "CHU": k = kana(16'h3061, KanaSmallYu);
         "CHO": k = kana(16'h3061, KanaSmallYo);
         "NYA": k = kana(16'h306B, KanaSmallYa);
         "NYU": k = kana(16'h306B, KanaSmallYu);
         "NYO": k = kana(16'h306B, KanaSmallYo);
         "HYA": k = kana(16'h3072, KanaSmallYa);
         "HYU": k = kana(16'h3072, KanaSmallYu);
         "HYO": k = kana(16'h3072, KanaSmallYo);
         "BYA": k = kana(16'h3073, KanaSmallYa);
         "BYU": k = kana(16'h3073, KanaSmallYu);
         "BYO": k = kana(16'h3073, KanaSmallYo);
         "PYA": k = kana(16'h3074, KanaSmallYa);
         "PYU": k = kana(16'h3074, KanaSmallYu);
         "PYO": k = kana(16'h3074, KanaSmallYo);
         "MYA": k = kana(16'h307F, KanaSmallYa);
         "MYU": k = kana(16'h307F, KanaSmallYu);
         "MYO": k = kana(16'h307F, KanaSmallYo);
         "RYA": k = kana(16'h308A, KanaSmallYa);
         "RYU": k = kana(16'h308A, KanaSmallYu);
         "RYO": k = kana(16'h308A, KanaSmallYo);
         default: k = '0;
      endcase
      key3 = k;
   endfunction

   // Two-letter keys.
   function automatic kana_type key2(input logic [15:0] t);
      kana_type k;
      k = '0;
      case (t)
         "AA": k = kana(16'h3042, 16'h0000);
         "II": k = kana(16'h3044, 16'h0000);
         "UU": k = kana(16'h3046, 16'h0000);
         "EE": k = kana(16'h3048, 16'h0000);
         "OO": k = kana(16'h304A, 16'h0000);
         "XA": k = kana(16'h3041, 16'h0000);
         "XI": k = kana(16'h3043, 16'h0000);
         "XU": k = kana(16'h3045, 16'h0000);
         "XE": k = kana(16'h3047, 16'h0000);
         "XO": k = kana(16'h3049, 16'h0000);
         "KA": k = kana(16'h304B, 16'h0000);
         "KI": k = kana(16'h304D, 16'h0000);
         "KU": k = kana(16'h304F, 16'h0000);
         "KE": k = kana(16'h3051, 16'h0000);
         "KO": k = kana(16'h3053, 16'h0000);
         "GA": k = kana(16'h304C, 16'h0000);
         "GI": k = kana(16'h304E, 16'h0000);
         "GU": k = kana(16'h3050, 16'h0000);
         "GE": k = kana(16'h3052, 16'h0000);
         "GO": k = kana(16'h3054, 16'h0000);
         "SA": k = kana(16'h3055, 16'h0000);
         "SU": k = kana(16'h3059, 16'h0000);
         "SE": k = kana(16'h305B, 16'h0000);
         "SO": k = kana(16'h305D, 16'h0000);
         "ZA": k = kana(16'h3056, 16'h0000);
         "JI": k = kana(16'h3058, 16'h0000);
         "ZI": k = kana(16'h3058, 16'h0000);
         "ZU": k = kana(16'h305A, 16'h0000);
         "ZE": k = kana(16'h305C, 16'h0000);
         "ZO": k = kana(16'h305E, 16'h0000);
         "TA": k = kana(16'h305F, 16'h0000);
         "TE": k = kana(16'h3066, 16'h0000);
         "TO": k = kana(16'h3068, 16'h0000);
         "DA": k = kana(16'h3060, 16'h0000);
         "DI": k = kana(16'h3062, 16'h0000);
         "DU": k = kana(16'h3065, 16'h0000);
         "DE": k = kana(16'h3067, 16'h0000);
         "DO": k = kana(16'h3069, 16'h0000);
         "NA": k = kana(16'h306A, 16'h0000);
         "NI": k = kana(16'h306B, 16'h0000);
         "NU": k = kana(16'h306C, 16'h0000);
         "NE": k = kana(16'h306D, 16'h0000);
         "NO": k = kana(16'h306E, 16'h0000);
         "NN": k = kana(16'h3093, 16'h0000);
         "HA": k = kana(16'h306F, 16'h0000);
         "HI": k = kana(16'h3072, 16'h0000);
         "FU": k = kana(16'h3075, 16'h0000);
         "HU": k = kana(16'h3075, 16'h0000);
         "HE": k = kana(16'h3078, 16'h0000);
         "HO": k = kana(16'h307B, 16'h0000);
         "BA": k = kana(16'h3070, 16'h0000);
         "BI": k = kana(16'h3073, 16'h0000);
         "BU": k = kana(16'h3076, 16'h0000);
         "BE": k = kana(16'h3079, 16'h0000);
         "BO": k = kana(16'h307C, 16'h0000);
         "PA": k = kana(16'h3071, 16'h0000);
         "PI": k = kana(16'h3074, 16'h0000);
         "PU": k = kana(16'h3077, 16'h0000);
         "PE": k = kana(16'h307A, 16'h0000);
         "PO": k = kana(16'h307D, 16'h0000);
         "MA": k = kana(16'h307E, 16'h0000);
         "MI": k = kana(16'h307F, 16'h0000);
         "MU": k = kana(16'h3080, 16'h0000);
         "ME": k = kana(16'h3081, 16'h0000);
         "MO": k = kana(16'h3082, 16'h0000);
         "YA": k = kana(16'h3084, 16'h0000);
         "YU": k = kana(16'h3086, 16'h0000);
         "YO": k = kana(16'h3088, 16'h0000);
         "RA": k = kana(16'h3089, 16'h0000);
         "RI": k = kana(16'h308A, 16'h0000);
         "RU": k = kana(16'h308B, 16'h0000);
         "RE": k = kana(16'h308C, 16'h0000);
         "RO": k = kana(16'h308D, 16'h0000);
         "WA": k = kana(16'h308F, 16'h0000);
         "WI": k = kana(16'h3090, 16'h0000);
         "WE": k = kana(16'h3091, 16'h0000);
         "WO": k = kana(16'h3092, 16'h0000);
         "JA": k = kana(16'h3058, KanaSmallYa);
         "JU": k = kana(16'h3058, KanaSmallYu);
         "JO": k = kana(16'h3058, KanaSmallYo);
         default: k = '0;
      endcase
      key2 = k;
   endfunction

   // Greedy longest match over the folded window; only keys no longer
   // than the number of held units are tried.
   function automatic match_type lookup(input logic [31:0] win, input logic [2:0] top);
      match_type m;
      kana_type  k3;
      kana_type  k2;
      k3 = key3(win[31:8]);
      k2 = key2(win[31:16]);
      m  = '0;
      m.len = 3'd1;
      if (top >= 3'd4 && win == "XTSU") begin
         m = '{1'b1, 3'd4, KanaSmallTsu, 16'h0000};
      end else if (top >= 3'd3 && k3.hit) begin
         m = '{1'b1, 3'd3, k3.first, k3.second};
      end else if (top >= 3'd2 && k2.hit) begin
         m = '{1'b1, 3'd2, k2.first, k2.second};
      end
      lookup = m;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/r2k_front.sv */
// ============================================================================
// Romaji to kana front end
// Accepts input items, folds each unit to upper-case ASCII and holds them
// in a short queue for the back end.
// ============================================================================
`default_nettype none

module r2k_front #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire r2k_pkg::req_type req_item,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output r2k_pkg::unit_type     pop_item
);

   localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

   r2k_pkg::unit_type queue_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push;
   logic            pop;
   r2k_pkg::unit_type push_item;

   // Handshakes and classification of the incoming unit.
   always_comb begin
      req_ready      = (count_ff != CntW'(QUEUE_DEPTH));
      pop_valid      = (count_ff != '0);
      pop_item       = queue_ff[rd_ptr_ff];
      push           = req_valid && req_ready;
      pop            = pop_valid && pop_ready;
      push_item.code = req_item.char_code;
      push_item.fold = r2k_pkg::fold_unit(req_item.char_code);
      push_item.last = req_item.last_char;
   end

   // Pointer and count updates with wraparound.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/r2k_back.sv */
// ============================================================================
// Romaji to kana back end
// Holds the lookahead window, makes greedy match decisions and emits
// results through a registered output; it takes no new unit mid-decision.
// ============================================================================
`default_nettype none

module r2k_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire r2k_pkg::unit_type pop_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output r2k_pkg::rsp_type       rsp_item
);

   localparam int unsigned Win = r2k_pkg::MaxKeyLen;

   r2k_pkg::state_type state_ff, state_in;
   logic [2:0]  fill_ff, fill_in;
   logic        flush_ff, flush_in;
   logic [15:0] code_ff [Win];
   logic [15:0] code_in [Win];
   logic [7:0]  fold_ff [Win];
   logic [7:0]  fold_in [Win];
   logic [15:0] second_ff, second_in;
   logic        rsp_valid_ff, rsp_valid_in;
   r2k_pkg::rsp_type rsp_ff, rsp_in;

   logic               slot_free;
   logic               append;
   r2k_pkg::match_type m;
   logic [2:0]         used;
   logic [2:0]         fill_after;
   logic [2:0]         src;

   // Window lookup and consumption count.
   always_comb begin
      slot_free  = !rsp_valid_ff || rsp_ready;
      append     = (state_ff == r2k_pkg::S_IDLE) && pop_valid;
      m          = r2k_pkg::lookup({fold_ff[0], fold_ff[1], fold_ff[2], fold_ff[3]},
                                   fill_ff);
      used       = m.hit ? m.len : 3'd1;
      fill_after = fill_ff - used;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         r2k_pkg::S_IDLE: begin
            if (pop_valid && (pop_item.last || fill_ff == 3'(Win - 1))) begin
               state_in = r2k_pkg::S_DECIDE;
            end
         end
         r2k_pkg::S_DECIDE: begin
            if (slot_free) begin
               if (m.hit && m.second != 16'h0000) begin
                  state_in = r2k_pkg::S_SECOND;
               end else if (flush_ff && fill_after != 3'd0) begin
                  state_in = r2k_pkg::S_DECIDE;
               end else begin
                  state_in = r2k_pkg::S_IDLE;
               end
            end
         end
         r2k_pkg::S_SECOND: begin
            if (slot_free) begin
               if (flush_ff && fill_ff != 3'd0) begin
                  state_in = r2k_pkg::S_DECIDE;
               end else begin
                  state_in = r2k_pkg::S_IDLE;
               end
            end
         end
         default: state_in = r2k_pkg::S_IDLE;
      endcase
   end

   // Window, output register and flush flag updates.
   always_comb begin
      pop_ready    = (state_ff == r2k_pkg::S_IDLE);
      fill_in      = fill_ff;
      flush_in     = flush_ff;
      second_in    = second_ff;
      code_in      = code_ff;
      fold_in      = fold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      src          = '0;
      if (append) begin
         code_in[fill_ff[1:0]] = pop_item.code;
         fold_in[fill_ff[1:0]] = pop_item.fold;
         fill_in               = fill_ff + 3'd1;
         flush_in              = pop_item.last;
      end
      if (state_ff == r2k_pkg::S_DECIDE && slot_free) begin
         // Emit the first unit of the decision and consume the key.
         rsp_valid_in       = 1'b1;
         rsp_in.out_code    = m.hit ? m.first : code_ff[0];
         rsp_in.from_table  = m.hit;
         rsp_in.run_last    = !(m.hit && m.second != 16'h0000) &&
                              (!flush_ff || fill_after == 3'd0);
         rsp_in.string_end  = rsp_in.run_last && flush_ff;
         second_in          = m.second;
         fill_in            = fill_after;
         for (int i = 0; i < Win; i++) begin
            src = 3'(i) + used;
            if (src < 3'(Win)) begin
               code_in[i] = code_ff[src[1:0]];
               fold_in[i] = fold_ff[src[1:0]];
            end
         end
      end
      if (state_ff == r2k_pkg::S_SECOND && slot_free) begin
         // Emit the second kana unit of a two-unit key.
         rsp_valid_in      = 1'b1;
         rsp_in.out_code   = second_ff;
         rsp_in.from_table = 1'b1;
         rsp_in.run_last   = !flush_ff || fill_ff == 3'd0;
         rsp_in.string_end = flush_ff && fill_ff == 3'd0;
      end
      if (state_in == r2k_pkg::S_IDLE) begin
         flush_in = 1'b0;
      end
      rsp_valid = rsp_valid_ff;
      rsp_item  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= r2k_pkg::S_IDLE;
         fill_ff      <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      fold_ff   <= fold_in;
      second_ff <= second_in;
      rsp_ff    <= rsp_in;
   end

   // The window never holds more units than its depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 3'(Win))
      else $error("window fill exceeds its depth");

   // A decision is only made with at least one unit in the window.
   a_decide_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == r2k_pkg::S_DECIDE |-> fill_ff != 3'd0)
      else $error("decision on an empty window");

   // The end of a string is always the last result of its item.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.string_end |-> rsp_ff.run_last)
      else $error("string end without run last");

   // Flushing never outlives the return to idle.
   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == r2k_pkg::S_IDLE |-> !flush_ff)
      else $error("flush pending while idle");

endmodule

`default_nettype wire

/* rtl/core/romaji_to_kana_greedy_match.sv */
// ============================================================================
// Romaji to kana greedy match
// Top level: a queueing front end feeds a window and decision back end.
// ============================================================================
// Each input item is one UTF-16 unit of a string; the last unit carries
// last_char. Units enter a four-unit lookahead window, and whenever it is
// full (or the string ends) the longest romaji key at the window head is
// replaced by one or two hiragana units; unmatched units pass through
// unchanged. The back end moves each unit into the window, and after a
// decision it emits that decision's results in turn; at the end of a
// string it keeps deciding until the window is empty. A queue of
// QUEUE_DEPTH items lets the input side keep going while the back end
// works.
`default_nettype none

module romaji_to_kana_greedy_match #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire r2k_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output r2k_pkg::rsp_type      rsp_item
);

   logic              pop_valid;
   logic              pop_ready;
   r2k_pkg::unit_type pop_item;

   // Input queue with case folding.
   r2k_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item (pop_item)
   );

   // Window, matching and result output.
   r2k_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item (pop_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

/* tb/romaji_to_kana_greedy_match_test.sv */
// ============================================================================
// Romaji to kana greedy match testbench
// Drives UTF-16 strings through the transliterator and compares every result
// item with a behavioral prediction of the greedy longest-match window.
// ============================================================================
`default_nettype none

module romaji_to_kana_greedy_match_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HoldOffCycles = 400;
   localparam int unsigned WatchdogLimit = 20000;
   localparam int unsigned RandomItems = 305;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   r2k_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   r2k_pkg::rsp_type rsp_item;

   romaji_to_kana_greedy_match uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item)
   );

   always #6 clock = ~clock;

   // Predicted lookahead window and the results waiting to be seen.
   logic [15:0]      kana_window [r2k_pkg::MaxKeyLen];
   int unsigned      kana_fill;
   r2k_pkg::rsp_type kana_pending[$];
   int unsigned      mismatch_count = 0;
   int unsigned      result_count = 0;
   int unsigned      string_count = 0;
   bit               stimulus_done = 1'b0;
   bit               hold_off = 1'b0;

   // Upper-case fold of a unit for key comparison; letters a-z only.
   function automatic logic [15:0] upper_unit(input logic [15:0] u);
      return (u >= 16'h61 && u <= 16'h7A) ? u - 16'h20 : u;
   endfunction

   // Kana for a key text of the given length; returns 0 on no key.
   function automatic bit romaji_kana(input string t, output logic [15:0] f,
                                      output logic [15:0] s);
      string   k2[$] = '{"AA","II","UU","EE","OO","XA","XI","XU","XE","XO",
         "KA","KI","KU","KE","KO","GA","GI","GU","GE","GO","SA","SU","SE","SO",
         "ZA","JI","ZI","ZU","ZE","ZO","TA","TE","TO","DA","DI","DU","DE","DO",
         "NA","NI","NU","NE","NO","NN","HA","HI","FU","HU","HE","HO",
         "BA","BI","BU","BE","BO","PA","PI","PU","PE","PO",
         "MA","MI","MU","ME","MO","YA","YU","YO","RA","RI","RU","RE","RO",
         "WA","WI","WE","WO"};
      logic [15:0] v2[$] = '{16'h3042,16'h3044,16'h3046,16'h3048,16'h304A,
         16'h3041,16'h3043,16'h3045,16'h3047,16'h3049,
         16'h304B,16'h304D,16'h304F,16'h3051,16'h3053,
         16'h304C,16'h304E,16'h3050,16'h3052,16'h3054,
         16'h3055,16'h3059,16'h305B,16'h305D,
         16'h3056,16'h3058,16'h3058,16'h305A,16'h305C,16'h305E,
         16'h305F,16'h3066,16'h3068,16'h3060,16'h3062,16'h3065,16'h3067,16'h3069,
         16'h306A,16'h306B,16'h306C,16'h306D,16'h306E,16'h3093,
         16'h306F,16'h3072,16'h3075,16'h3075,16'h3078,16'h307B,
         16'h3070,16'h3073,16'h3076,16'h3079,16'h307C,
         16'h3071,16'h3074,16'h3077,16'h307A,16'h307D,
         16'h307E,16'h307F,16'h3080,16'h3081,16'h3082,16'h3084,16'h3086,16'h3088,
         16'h3089,16'h308A,16'h308B,16'h308C,16'h308D,
         16'h308F,16'h3090,16'h3091,16'h3092};
      string   yoon_heads = "KGSZCNHBPMR";
      logic [15:0] yoon_kana[11] = '{16'h304D,16'h304E,16'h3057,16'h3058,
         16'h3061,16'h306B,16'h3072,16'h3073,16'h3074,16'h307F,16'h308A};
      logic [15:0] small_y;
      f = '0;
      s = '0;
      if (t == "XTSU") begin
         f = 16'h3063;
         return 1'b1;
      end
      if (t.len() == 3) begin
         if (t == "XYA") f = 16'h3083;
         if (t == "XYU") f = 16'h3085;
         if (t == "XYO") f = 16'h3087;
         if (t == "SHI") f = 16'h3057;
         if (t == "CHI") f = 16'h3061;
         if (t == "TSU") f = 16'h3064;
         if (f != 0) return 1'b1;
         small_y = (t[2] == "A") ? 16'h3083 : (t[2] == "U") ? 16'h3085 :
                   (t[2] == "O") ? 16'h3087 : 16'h0000;
         if (small_y == 0) return 1'b0;
         // Contracted sounds: consonant + Y, plus the SH and CH spellings.
         for (int i = 0; i < 11; i++) begin
            if (t[0] == yoon_heads[i] && t[1] == "Y" && !(t[0] inside {"S","C"})) begin
               f = yoon_kana[i];
               s = small_y;
               return 1'b1;
            end
         end
         if (t[1] == "H" && (t[0] == "S" || t[0] == "C")) begin
            f = (t[0] == "S") ? 16'h3057 : 16'h3061;
            s = small_y;
            return 1'b1;
         end
         return 1'b0;
      end
      if (t == "JA" || t == "JU" || t == "JO") begin
         f = 16'h3058;
         s = (t == "JA") ? 16'h3083 : (t == "JU") ? 16'h3085 : 16'h3087;
         return 1'b1;
      end
      foreach (k2[i]) begin
         if (k2[i] == t) begin
            f = v2[i];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // One greedy decision on the predicted window; appends results to the list.
   function automatic void decide_window(ref r2k_pkg::rsp_type res[$]);
      int unsigned used = 1;
      bit          found = 1'b0;
      logic [15:0] f, s;
      string       t;
      bit          ascii;
      for (int len = (kana_fill < r2k_pkg::MaxKeyLen ? kana_fill : r2k_pkg::MaxKeyLen);
           len >= 2 && !found; len--) begin
         t = "";
         ascii = 1'b1;
         for (int i = 0; i < len; i++) begin
            if (upper_unit(kana_window[i]) > 16'h7F || kana_window[i] == 0) ascii = 1'b0;
            else t = {t, string'(byte'(upper_unit(kana_window[i])))};
         end
         if (ascii && romaji_kana(t, f, s)) begin
            res.push_back('{out_code: f, from_table: 1'b1, run_last: 1'b0, string_end: 1'b0});
            if (s != 0)
               res.push_back('{out_code: s, from_table: 1'b1, run_last: 1'b0,
                               string_end: 1'b0});
            used = len;
            found = 1'b1;
         end
      end
      if (!found)
         res.push_back('{out_code: kana_window[0], from_table: 1'b0, run_last: 1'b0,
                         string_end: 1'b0});
      if (used > kana_fill) used = kana_fill;
      for (int i = 0; i < r2k_pkg::MaxKeyLen; i++)
         kana_window[i] = (i + used < r2k_pkg::MaxKeyLen) ? kana_window[i + used] : 16'h0000;
      kana_fill -= used;
   endfunction

   // Expected results for one accepted unit.
   function automatic void predict_kana(input r2k_pkg::req_type it,
                                        ref r2k_pkg::rsp_type res[$]);
      res.delete();
      if (kana_fill >= r2k_pkg::MaxKeyLen) decide_window(res);
      kana_window[kana_fill] = it.char_code;
      kana_fill++;
      if (it.last_char) begin
         while (kana_fill > 0) decide_window(res);
      end else if (kana_fill >= r2k_pkg::MaxKeyLen) begin
         decide_window(res);
      end
      if (res.size() > 0) begin
         res[res.size() - 1].run_last = 1'b1;
         res[res.size() - 1].string_end = it.last_char;
      end
   endfunction

   // Compare one delivered result with the oldest expectation.
   task automatic check_result(input r2k_pkg::rsp_type got);
      r2k_pkg::rsp_type want;
      result_count++;
      if (kana_pending.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result %h", got);
         return;
      end
      want = kana_pending.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: expected code %h tbl %b rl %b end %b, got %h %b %b %b",
                     want.out_code, want.from_table, want.run_last, want.string_end,
                     got.out_code, got.from_table, got.run_last, got.string_end);
      end
   endtask

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result(rsp_item);
   end

   // Receiver: stalls on its own pattern, with one long hold-off on request.
   int unsigned stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_off) rsp_ready <= 1'b0;
      else if (stall_phase[9:7] == 3'd2) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // Watchdog on cycles without any handshake.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || hold_off)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("watchdog expired");
         $display("romaji_to_kana_greedy_match_test: errors");
         $finish;
      end
   end

   // Offer one unit and wait for acceptance; burst gaps come from the caller.
   task automatic send_unit(input logic [15:0] code, input logic last);
      r2k_pkg::rsp_type res[$];
      req_item <= '{char_code: code, last_char: last};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_kana('{char_code: code, last_char: last}, res);
      foreach (res[i]) kana_pending.push_back(res[i]);
      if (last) string_count++;
   endtask

   // Burst gap: with some chance lower valid for a random number of cycles.
   int unsigned burst_left = 0;
   task automatic sender_gap();
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Directed stimulus table: code and last flag, checked against the prediction.
   typedef struct {
      logic [15:0] code;
      logic        last;
   } unit_row_type;

   unit_row_type direct_rows[] = '{
      '{16'h0000, 1'b1},                     // lone zero unit passes through
      '{16'hFFFF, 1'b1},                     // lone top unit passes through
      '{"x", 1'b0}, '{"t", 1'b0}, '{"s", 1'b0}, '{"u", 1'b1},   // four-letter key
      '{"K", 1'b0}, '{"y", 1'b0}, '{"a", 1'b0}, '{"n", 1'b0},
      '{"N", 1'b1},                          // two-unit kana then NN
      '{"j", 1'b0}, '{"A", 1'b1},            // short window flush
      '{16'h3042, 1'b0}, '{"k", 1'b0}, '{"A", 1'b0}, '{16'h8061, 1'b0},
      '{"@", 1'b0}, '{"{", 1'b1},            // non-ASCII and letter neighbors
      '{"s", 1'b0}, '{"h", 1'b0}, '{"i", 1'b0}, '{"b", 1'b1},
      '{"q", 1'b1}
   };

   // Random string content: mostly romaji syllables, some noise.
   string syllables[$] = '{"ka","shi","tsu","chi","kyo","nn","xtsu","ja","zi","hu",
      "ryu","xya","aa","wo","pyo","ga","fu","mo","a","n","y","x"};

   // Stimulus process.
   initial begin
      string       syl;
      int unsigned sent;
      logic [15:0] u;
      bit          last;
      for (int i = 0; i < r2k_pkg::MaxKeyLen; i++) kana_window[i] = 16'h0000;
      kana_fill = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (direct_rows[i]) send_unit(direct_rows[i].code, direct_rows[i].last);
      req_valid <= 1'b0;

      // Long receiver hold-off while the sender keeps offering units.
      fork
         begin
            hold_off = 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 30; i++) send_unit(16'("k" + (i % 3)), (i % 7) == 6);
      join
      req_valid <= 1'b0;

      sent = 0;
      while (sent < RandomItems) begin
         syl = syllables[$urandom_range(0, syllables.size() - 1)];
         for (int c = 0; c < syl.len(); c++) begin
            u = 16'(syl[c]);
            if ($urandom_range(0, 1)) u = upper_unit(u);
            if ($urandom_range(0, 15) == 0) u = 16'($urandom_range(0, 65535));
            last = (c == syl.len() - 1) && ($urandom_range(0, 5) == 0);
            sender_gap();
            send_unit(u, last);
            sent++;
         end
      end
      send_unit(16'($urandom_range(0, 65535)), 1'b1);
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // End of run.
   initial begin
      wait (stimulus_done);
      while (kana_pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("ran %0d strings, %0d results checked, %0d mismatches",
               string_count, result_count, mismatch_count);
      if (mismatch_count == 0 && kana_pending.size() == 0) begin
         $display("romaji_to_kana_greedy_match_test: clean");
      end else begin
         $display("romaji_to_kana_greedy_match_test: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/core/r2k_pkg.sv
rtl/core/r2k_front.sv
rtl/core/r2k_back.sv
rtl/core/romaji_to_kana_greedy_match.sv
tb/romaji_to_kana_greedy_match_test.sv
